>>> hdl/pabl_pkg.sv
// Shared types, codes and constants for the per-address backoff limiter.
// No dependencies; imported by every module of the block.
package pabl_pkg;

    localparam int SLOTS_DEFAULT = 8;
    localparam int ADDR_W        = 32;
    localparam int TIME_W        = 32;
    localparam int DELAY_W       = 30;
    localparam int TYPE_W        = 2;
    localparam int CFG_IDX_W     = 1;

    localparam logic [DELAY_W-1:0] INITIAL_DELAY_RESET = DELAY_W'(1000);
    localparam logic [DELAY_W-1:0] MAX_DELAY_RESET     = DELAY_W'(60000);

    localparam logic [TYPE_W-1:0] REQ_CHECK   = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_FAIL    = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_SUCCESS = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DELAY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY     = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_CALC,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic calc;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic last_issue;
    } status_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        logic [DELAY_W-1:0] delay;
        logic [TIME_W-1:0]  blocked_until;
        logic [TIME_W-1:0]  last_attempt;
    } entry_t;

    // signed wrapping difference a - b is negative
    function automatic logic wrap_before(input logic [TIME_W-1:0] a,
                                         input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] diff;
        diff = a - b;
        return diff[TIME_W-1];
    endfunction

endpackage

>>> hdl/per_address_backoff_limiter.sv
// Channel   | handshake        | payload
// request   | start / busy     | req_type, client_address, now_ms
// result    | done (strobe)    | blocked, tracked, current_delay_ms
// config    | cfg_we           | cfg_index, cfg_data
//
// done is registered from the commit state, which follows the scan of the slot memory through
// its single read port, one slot a cycle, and then the drain and calc states.
// The next request may be accepted in the cycle that done is high.
// Reset clears all slot valid bits at once and loads the default delays; no sweep.
// Results are strobed for one cycle and cannot be held off.
// Top level; depends on pabl_pkg, pabl_ctrl and pabl_dp.
module per_address_backoff_limiter #(
    parameter int TABLE_SLOTS = pabl_pkg::SLOTS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [pabl_pkg::TYPE_W-1:0]        req_type,
    input  logic [pabl_pkg::ADDR_W-1:0]        client_address,
    input  logic [pabl_pkg::TIME_W-1:0]        now_ms,
    output logic                               done,
    output logic                               blocked,
    output logic                               tracked,
    output logic [pabl_pkg::DELAY_W-1:0]       current_delay_ms,
    input  logic                               cfg_we,
    input  logic [pabl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pabl_pkg::DELAY_W-1:0]       cfg_data
);
    import pabl_pkg::*;

    cmd_t    cmd;
    status_t status;

    pabl_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    pabl_dp #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .req_type         (req_type),
        .client_address   (client_address),
        .now_ms           (now_ms),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .done             (done),
        .blocked          (blocked),
        .tracked          (tracked),
        .current_delay_ms (current_delay_ms)
    );

endmodule

>>> hdl/pabl_ctrl.sv
// Sequencer for the backoff limiter: scan, drain, calculate, commit.
// Depends on pabl_pkg; drives pabl_dp through cmd_t, reads status_t.
module pabl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  pabl_pkg::status_t status,
    output pabl_pkg::cmd_t    cmd,
    output logic              busy
);
    import pabl_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_CALC;
            ST_CALC:   state_next = ST_COMMIT;
            ST_COMMIT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_SCAN:   cmd.issue  = 1'b1;
            ST_DRAIN:  cmd        = '0;
            ST_CALC:   cmd.calc   = 1'b1;
            ST_COMMIT: cmd.commit = 1'b1;
            default:   cmd        = '0;
        endcase
    end

endmodule

>>> hdl/pabl_dp.sv
// Datapath: request registers, config registers, slot memory, scan and update.
// Depends on pabl_pkg; steered by pabl_ctrl through cmd_t.
module pabl_dp #(
    parameter int TABLE_SLOTS = pabl_pkg::SLOTS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pabl_pkg::cmd_t                     cmd,
    output pabl_pkg::status_t                  status,
    input  logic [pabl_pkg::TYPE_W-1:0]        req_type,
    input  logic [pabl_pkg::ADDR_W-1:0]        client_address,
    input  logic [pabl_pkg::TIME_W-1:0]        now_ms,
    input  logic                               cfg_we,
    input  logic [pabl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pabl_pkg::DELAY_W-1:0]       cfg_data,
    output logic                               done,
    output logic                               blocked,
    output logic                               tracked,
    output logic [pabl_pkg::DELAY_W-1:0]       current_delay_ms
);
    import pabl_pkg::*;

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

    entry_t slot_mem [TABLE_SLOTS];

    logic [TABLE_SLOTS-1:0] valid_reg;
    logic [TABLE_SLOTS-1:0] valid_next;

    logic [DELAY_W-1:0] initial_delay_reg;
    logic [DELAY_W-1:0] max_delay_reg;

    logic [TYPE_W-1:0]  type_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [TIME_W-1:0]  now_reg;

    logic [IDX_W-1:0]   rd_idx_reg;
    logic [IDX_W-1:0]   rd_idx_next;
    logic               cmp_valid_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic               cmp_slot_valid_reg;
    entry_t             rd_data_reg;

    logic               match_found_reg;
    logic [IDX_W-1:0]   match_idx_reg;
    logic [DELAY_W-1:0] match_delay_reg;
    logic [TIME_W-1:0]  match_bu_reg;
    logic               free_found_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic               oldest_found_reg;
    logic [IDX_W-1:0]   oldest_idx_reg;
    logic [TIME_W-1:0]  oldest_last_reg;

    logic [IDX_W-1:0]   pick_idx_reg;
    logic [DELAY_W-1:0] new_delay_reg;
    logic [DELAY_W-1:0] new_delay_next;

    logic               done_reg;
    logic               blocked_reg;
    logic               tracked_reg;
    logic [DELAY_W-1:0] delay_out_reg;

    logic               is_fail;
    logic               is_success;
    logic               hit;
    logic               older;
    logic [DELAY_W-1:0] base_delay;
    entry_t             wr_entry;

    assign is_fail    = (type_reg == REQ_FAIL);
    assign is_success = (type_reg == REQ_SUCCESS);

    assign status.last_issue = (rd_idx_reg == LAST_IDX);
    assign rd_idx_next       = cmd.load ? '0 : (rd_idx_reg + IDX_W'(1));

    assign hit   = cmp_slot_valid_reg && (rd_data_reg.address == addr_reg);
    assign older = !oldest_found_reg
                   || wrap_before(rd_data_reg.last_attempt, oldest_last_reg);

    always_comb
    begin
        base_delay = match_found_reg ? match_delay_reg : '0;
        if (base_delay == '0)
        begin
            new_delay_next = initial_delay_reg;
        end
        else if (base_delay >= (max_delay_reg >> 1))
        begin
            new_delay_next = max_delay_reg;
        end
        else
        begin
            new_delay_next = {base_delay[DELAY_W-2:0], 1'b0};
        end
    end

    always_comb
    begin
        wr_entry.address       = addr_reg;
        wr_entry.delay         = new_delay_reg;
        wr_entry.blocked_until = now_reg + {{(TIME_W-DELAY_W){1'b0}}, new_delay_reg};
        wr_entry.last_attempt  = now_reg;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.commit)
        begin
            if (is_fail)
            begin
                valid_next[pick_idx_reg] = 1'b1;
            end
            else if (is_success && match_found_reg)
            begin
                valid_next[match_idx_reg] = 1'b0;
            end
        end
    end

    // slot memory: one read port, one write port, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            rd_data_reg <= slot_mem[rd_idx_reg];
        end
        if (cmd.commit && is_fail)
        begin
            slot_mem[pick_idx_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg          <= '0;
            initial_delay_reg  <= INITIAL_DELAY_RESET;
            max_delay_reg      <= MAX_DELAY_RESET;
            rd_idx_reg         <= '0;
            cmp_valid_reg      <= 1'b0;
            match_found_reg    <= 1'b0;
            free_found_reg     <= 1'b0;
            oldest_found_reg   <= 1'b0;
            done_reg           <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            cmp_valid_reg <= cmd.issue;
            done_reg      <= cmd.commit;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_INITIAL_DELAY: initial_delay_reg <= cfg_data;
                    CFG_MAX_DELAY:     max_delay_reg     <= cfg_data;
                    default:           initial_delay_reg <= initial_delay_reg;
                endcase
            end
            if (cmd.load || cmd.issue)
            begin
                rd_idx_reg <= rd_idx_next;
            end
            if (cmd.load)
            begin
                match_found_reg  <= 1'b0;
                free_found_reg   <= 1'b0;
                oldest_found_reg <= 1'b0;
            end
            else if (cmp_valid_reg)
            begin
                if (hit)
                begin
                    match_found_reg <= 1'b1;
                end
                if (!cmp_slot_valid_reg)
                begin
                    free_found_reg <= 1'b1;
                end
                if (cmp_slot_valid_reg)
                begin
                    oldest_found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            type_reg <= req_type;
            addr_reg <= client_address;
            now_reg  <= now_ms;
        end
        if (cmd.issue)
        begin
            cmp_idx_reg        <= rd_idx_reg;
            cmp_slot_valid_reg <= valid_reg[rd_idx_reg];
        end
        if (cmp_valid_reg)
        begin
            if (hit && !match_found_reg)
            begin
                match_idx_reg   <= cmp_idx_reg;
                match_delay_reg <= rd_data_reg.delay;
                match_bu_reg    <= rd_data_reg.blocked_until;
            end
            if (!cmp_slot_valid_reg && !free_found_reg)
            begin
                free_idx_reg <= cmp_idx_reg;
            end
            if (cmp_slot_valid_reg && older)
            begin
                oldest_idx_reg  <= cmp_idx_reg;
                oldest_last_reg <= rd_data_reg.last_attempt;
            end
        end
        if (cmd.calc)
        begin
            new_delay_reg <= new_delay_next;
            priority if (match_found_reg)
            begin
                pick_idx_reg <= match_idx_reg;
            end
            else if (free_found_reg)
            begin
                pick_idx_reg <= free_idx_reg;
            end
            else
            begin
                pick_idx_reg <= oldest_idx_reg;
            end
        end
        if (cmd.commit)
        begin
            priority if (is_fail)
            begin
                blocked_reg   <= 1'b0;
                tracked_reg   <= 1'b1;
                delay_out_reg <= new_delay_reg;
            end
            else if (is_success)
            begin
                blocked_reg   <= 1'b0;
                tracked_reg   <= 1'b0;
                delay_out_reg <= '0;
            end
            else
            begin
                blocked_reg   <= match_found_reg && (match_delay_reg != '0)
                                 && wrap_before(now_reg, match_bu_reg);
                tracked_reg   <= match_found_reg;
                delay_out_reg <= match_found_reg ? match_delay_reg : '0;
            end
        end
    end

    assign done             = done_reg;
    assign blocked          = blocked_reg;
    assign tracked          = tracked_reg;
    assign current_delay_ms = delay_out_reg;

endmodule

>>> hdl/pabl_checker.sv
// Port-level checks for the backoff limiter, bound to the top level.
// Depends on pabl_pkg for field widths.
module pabl_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic                         blocked,
    input logic                         tracked,
    input logic [pabl_pkg::DELAY_W-1:0] current_delay_ms
);
    import pabl_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but busy not raised");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while still busy");

    a_untracked_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !tracked) |-> (current_delay_ms == '0))
        else $error("untracked address reports a delay");

    a_blocked_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        (done && blocked) |-> (tracked && (current_delay_ms != '0)))
        else $error("blocked without a tracked nonzero delay");

endmodule

bind per_address_backoff_limiter pabl_checker u_pabl_checker (.*);
